### sv/pdbf_pkg.sv
// shared constants and the arctangent table of the pose delta to body frame unit
`default_nettype none

package pdbf_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANG_BITS     = 32;
    localparam int CS_WIDTH     = 34;
    localparam int FRAC_BITS    = 30;

    localparam logic signed [CS_WIDTH-1:0] INV_GAIN = 34'sd652032874;

    function automatic logic signed [CS_WIDTH-1:0] atan_entry(input int unsigned idx);
        logic signed [CS_WIDTH-1:0] v;
        case (idx)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            24:      v = 34'sd41;
            25:      v = 34'sd20;
            26:      v = 34'sd10;
            27:      v = 34'sd5;
            28:      v = 34'sd3;
            29:      v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/pdbf_prep.sv
// input stage: world displacement, cordic start angle with half turn fold, heading change
`default_nettype none

module pdbf_prep #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]        i_prev_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_prev_y,
    input  wire logic signed [ANGLE_WIDTH-1:0]        i_prev_heading,
    input  wire logic signed [COORD_WIDTH-1:0]        i_cur_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_cur_y,
    input  wire logic signed [ANGLE_WIDTH-1:0]        i_cur_heading,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [COORD_WIDTH:0]               o_dx,
    output logic signed [COORD_WIDTH:0]               o_dy,
    output logic signed [pdbf_pkg::CS_WIDTH-1:0]      o_z,
    output logic                                      o_flip,
    output logic signed [ANGLE_WIDTH-1:0]             o_turn
);

    localparam int DW = COORD_WIDTH + 1;

    logic                                  r_valid;
    logic                                  w_adv;
    logic [pdbf_pkg::ANG_BITS-1:0]         w_ang;
    logic signed [DW-1:0]                  n_dx, n_dy;
    logic signed [pdbf_pkg::CS_WIDTH-1:0]  n_z;
    logic                                  n_flip;
    logic signed [ANGLE_WIDTH-1:0]         n_turn;
    logic signed [DW-1:0]                  r_dx, r_dy;
    logic signed [pdbf_pkg::CS_WIDTH-1:0]  r_z;
    logic                                  r_flip;
    logic signed [ANGLE_WIDTH-1:0]         r_turn;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_valid;

    always_comb begin
        w_ang  = pdbf_pkg::ANG_BITS'(i_prev_heading) << (pdbf_pkg::ANG_BITS - ANGLE_WIDTH);
        n_dx   = DW'(i_cur_x) - DW'(i_prev_x);
        n_dy   = DW'(i_cur_y) - DW'(i_prev_y);
        // second and third quadrant fold by a half turn
        n_flip = w_ang[pdbf_pkg::ANG_BITS-1] ^ w_ang[pdbf_pkg::ANG_BITS-2];
        n_z    = pdbf_pkg::CS_WIDTH'($signed({w_ang[pdbf_pkg::ANG_BITS-2],
                                              w_ang[pdbf_pkg::ANG_BITS-2:0]}));
        n_turn = i_cur_heading - i_prev_heading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_z    <= n_z;
            r_flip <= n_flip;
            r_turn <= n_turn;
        end
    end

    assign o_dx   = r_dx;
    assign o_dy   = r_dy;
    assign o_z    = r_z;
    assign o_flip = r_flip;
    assign o_turn = r_turn;

endmodule

`default_nettype wire

### sv/pdbf_cordic.sv
// pipelined rotation cordic, one iteration per stage, then quadrant unfold
`default_nettype none

module pdbf_cordic #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [COORD_WIDTH:0]          i_dx,
    input  wire logic signed [COORD_WIDTH:0]          i_dy,
    input  wire logic signed [pdbf_pkg::CS_WIDTH-1:0] i_z,
    input  wire logic                                 i_flip,
    input  wire logic signed [ANGLE_WIDTH-1:0]        i_turn,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [COORD_WIDTH:0]               o_dx,
    output logic signed [COORD_WIDTH:0]               o_dy,
    output logic signed [pdbf_pkg::CS_WIDTH-1:0]      o_cos,
    output logic signed [pdbf_pkg::CS_WIDTH-1:0]      o_sin,
    output logic signed [pdbf_pkg::CS_WIDTH-1:0]      o_nsin,
    output logic signed [ANGLE_WIDTH-1:0]             o_turn
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int CS    = pdbf_pkg::CS_WIDTH;
    localparam int STEPS = pdbf_pkg::CORDIC_STEPS;
    localparam int NS    = STEPS + 1;

    logic                          r_v    [NS];
    logic                          w_adv  [NS];
    logic signed [DW-1:0]          r_dx   [NS];
    logic signed [DW-1:0]          r_dy   [NS];
    logic                          r_flip [NS];
    logic signed [ANGLE_WIDTH-1:0] r_turn [NS];
    logic signed [CS-1:0]          r_x    [STEPS];
    logic signed [CS-1:0]          r_y    [STEPS];
    logic signed [CS-1:0]          r_z    [STEPS];
    logic signed [CS-1:0]          r_cos, r_sin, r_nsin;

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic                          v_in;
        logic signed [DW-1:0]          dx_in, dy_in;
        logic                          flip_in;
        logic signed [ANGLE_WIDTH-1:0] turn_in;
        logic signed [CS-1:0]          x_in, y_in;

        if (k == 0) begin : g_src
            assign v_in    = i_valid;
            assign dx_in   = i_dx;
            assign dy_in   = i_dy;
            assign flip_in = i_flip;
            assign turn_in = i_turn;
            assign x_in    = pdbf_pkg::INV_GAIN;
            assign y_in    = '0;
        end else begin : g_src
            assign v_in    = r_v[k-1];
            assign dx_in   = r_dx[k-1];
            assign dy_in   = r_dy[k-1];
            assign flip_in = r_flip[k-1];
            assign turn_in = r_turn[k-1];
            assign x_in    = r_x[k-1];
            assign y_in    = r_y[k-1];
        end

        if (k == NS - 1) begin : g_adv
            assign w_adv[k] = !r_v[k] || !i_stall;
        end else begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k] && v_in) begin
                r_dx[k]   <= dx_in;
                r_dy[k]   <= dy_in;
                r_flip[k] <= flip_in;
                r_turn[k] <= turn_in;
            end
        end

        if (k < STEPS) begin : g_iter
            logic signed [CS-1:0] z_in;
            logic signed [CS-1:0] xs, ys, atn;
            logic signed [CS-1:0] n_x, n_y, n_z;

            if (k == 0) begin : g_zsrc
                assign z_in = i_z;
            end else begin : g_zsrc
                assign z_in = r_z[k-1];
            end

            always_comb begin
                xs  = x_in >>> k;
                ys  = y_in >>> k;
                atn = pdbf_pkg::atan_entry(k);
                if (!z_in[CS-1]) begin
                    n_x = x_in - ys;
                    n_y = y_in + xs;
                    n_z = z_in - atn;
                end else begin
                    n_x = x_in + ys;
                    n_y = y_in - xs;
                    n_z = z_in + atn;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[k] && v_in) begin
                    r_x[k] <= n_x;
                    r_y[k] <= n_y;
                    r_z[k] <= n_z;
                end
            end
        end else begin : g_unfold
            always_ff @(posedge i_clk) begin
                if (w_adv[k] && v_in) begin
                    r_cos  <= flip_in ? -x_in : x_in;
                    r_sin  <= flip_in ? -y_in : y_in;
                    r_nsin <= flip_in ? y_in : -y_in;
                end
            end
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_v[NS-1];
    assign o_dx    = r_dx[NS-1];
    assign o_dy    = r_dy[NS-1];
    assign o_turn  = r_turn[NS-1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_nsin  = r_nsin;

endmodule

`default_nettype wire

### sv/pdbf_rotate.sv
// split products, sums, q30 round half up and saturation of the body frame motion
`default_nettype none

module pdbf_rotate #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [COORD_WIDTH:0]          i_dx,
    input  wire logic signed [COORD_WIDTH:0]          i_dy,
    input  wire logic signed [pdbf_pkg::CS_WIDTH-1:0] i_cos,
    input  wire logic signed [pdbf_pkg::CS_WIDTH-1:0] i_sin,
    input  wire logic signed [pdbf_pkg::CS_WIDTH-1:0] i_nsin,
    input  wire logic signed [ANGLE_WIDTH-1:0]        i_turn,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [COORD_WIDTH-1:0]             o_forward_move,
    output logic signed [COORD_WIDTH-1:0]             o_lateral_move,
    output logic signed [ANGLE_WIDTH-1:0]             o_turn,
    output logic                                      o_saturated
);

    localparam int CS    = pdbf_pkg::CS_WIDTH;
    localparam int FRAC  = pdbf_pkg::FRAC_BITS;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int SPLIT = DW / 2;
    localparam int HW    = DW - SPLIT;
    localparam int LW    = SPLIT + 1;
    localparam int PH    = HW + CS;
    localparam int PL    = LW + CS;
    localparam int SH    = PH + 1;
    localparam int SL    = PL + 1;
    localparam int TW    = SH + SPLIT + 1;
    localparam int QW    = TW - FRAC;
    localparam int NST   = 4;

    localparam logic signed [TW-1:0] HALF_LSB = TW'(1) <<< (FRAC - 1);
    localparam logic signed [QW-1:0] SAT_HI   = QW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    localparam logic signed [QW-1:0] SAT_LO   = QW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

    logic                          r_v   [NST];
    logic                          w_adv [NST];
    logic signed [ANGLE_WIDTH-1:0] r_turn[NST];

    logic signed [HW-1:0] w_dxh, w_dyh;
    logic signed [LW-1:0] w_dxl, w_dyl;

    logic signed [PH-1:0] r_fxh, r_fyh, r_lxh, r_lyh;
    logic signed [PL-1:0] r_fxl, r_fyl, r_lxl, r_lyl;
    logic signed [SH-1:0] r_fhi, r_lhi;
    logic signed [SL-1:0] r_flo, r_llo;
    logic signed [TW-1:0] w_ft, w_lt;
    logic signed [QW-1:0] r_fq, r_lq;
    logic signed [COORD_WIDTH-1:0] n_fwd, n_lat, r_fwd, r_lat;
    logic                 n_sat, r_sat;

    assign w_adv[NST-1] = !r_v[NST-1] || !i_stall;
    for (genvar k = 0; k < NST - 1; k++) begin : g_adv
        assign w_adv[k] = !r_v[k] || w_adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_dxh = $signed(i_dx[DW-1:SPLIT]);
    assign w_dyh = $signed(i_dy[DW-1:SPLIT]);
    assign w_dxl = $signed({1'b0, i_dx[SPLIT-1:0]});
    assign w_dyl = $signed({1'b0, i_dy[SPLIT-1:0]});

    // partial products
    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r_fxh     <= PH'(w_dxh) * PH'(i_cos);
            r_fxl     <= PL'(w_dxl) * PL'(i_cos);
            r_fyh     <= PH'(w_dyh) * PH'(i_sin);
            r_fyl     <= PL'(w_dyl) * PL'(i_sin);
            r_lxh     <= PH'(w_dxh) * PH'(i_nsin);
            r_lxl     <= PL'(w_dxl) * PL'(i_nsin);
            r_lyh     <= PH'(w_dyh) * PH'(i_cos);
            r_lyl     <= PL'(w_dyl) * PL'(i_cos);
            r_turn[0] <= i_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1] && r_v[0]) begin
            r_fhi     <= SH'(r_fxh) + SH'(r_fyh);
            r_flo     <= SL'(r_fxl) + SL'(r_fyl);
            r_lhi     <= SH'(r_lxh) + SH'(r_lyh);
            r_llo     <= SL'(r_lxl) + SL'(r_lyl);
            r_turn[1] <= r_turn[0];
        end
    end

    assign w_ft = (TW'(r_fhi) <<< SPLIT) + TW'(r_flo) + HALF_LSB;
    assign w_lt = (TW'(r_lhi) <<< SPLIT) + TW'(r_llo) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (w_adv[2] && r_v[1]) begin
            r_fq      <= QW'(w_ft >>> FRAC);
            r_lq      <= QW'(w_lt >>> FRAC);
            r_turn[2] <= r_turn[1];
        end
    end

    always_comb begin
        n_sat = 1'b0;
        if (r_fq > SAT_HI) begin
            n_fwd = COORD_WIDTH'(SAT_HI);
            n_sat = 1'b1;
        end else if (r_fq < SAT_LO) begin
            n_fwd = COORD_WIDTH'(SAT_LO);
            n_sat = 1'b1;
        end else begin
            n_fwd = COORD_WIDTH'(r_fq);
        end
        if (r_lq > SAT_HI) begin
            n_lat = COORD_WIDTH'(SAT_HI);
            n_sat = 1'b1;
        end else if (r_lq < SAT_LO) begin
            n_lat = COORD_WIDTH'(SAT_LO);
            n_sat = 1'b1;
        end else begin
            n_lat = COORD_WIDTH'(r_lq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3] && r_v[2]) begin
            r_fwd     <= n_fwd;
            r_lat     <= n_lat;
            r_sat     <= n_sat;
            r_turn[3] <= r_turn[2];
        end
    end

    assign o_stall        = !w_adv[0];
    assign o_valid        = r_v[NST-1];
    assign o_forward_move = r_fwd;
    assign o_lateral_move = r_lat;
    assign o_turn         = r_turn[NST-1];
    assign o_saturated    = r_sat;

endmodule

`default_nettype wire

### sv/pose_delta_to_body_frame_unit.sv
// top level: planar pose delta rotated into the previous pose's body frame
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | i_valid / o_stall  | i_prev_x, i_prev_y, i_prev_heading,
//           |                    | i_cur_x, i_cur_y, i_cur_heading
//  output   | o_valid / i_stall  | o_forward_move, o_lateral_move, o_turn,
//           |                    | o_saturated
//
// one item per cycle while the output is not stalled; stages: 1 prep, 30 cordic iterations, 1 unfold,
// 4 multiply/sum/round/saturate stages
// every stage has its own valid bit and advances when empty or when the next one moves,
// so bubbles close up while the output is stalled and up to 36 items sit in flight
// synchronous active low reset clears the valid bits only
`default_nettype none

module pose_delta_to_body_frame_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_prev_y,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_prev_heading,
    input  wire logic signed [COORD_WIDTH-1:0] i_cur_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_cur_y,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_cur_heading,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0]      o_forward_move,
    output logic signed [COORD_WIDTH-1:0]      o_lateral_move,
    output logic signed [ANGLE_WIDTH-1:0]      o_turn,
    output logic                               o_saturated
);

    localparam int CS = pdbf_pkg::CS_WIDTH;

    logic                          w_p_valid, w_p_stall;
    logic signed [COORD_WIDTH:0]   w_p_dx, w_p_dy;
    logic signed [CS-1:0]          w_p_z;
    logic                          w_p_flip;
    logic signed [ANGLE_WIDTH-1:0] w_p_turn;

    logic                          w_c_valid, w_c_stall;
    logic signed [COORD_WIDTH:0]   w_c_dx, w_c_dy;
    logic signed [CS-1:0]          w_c_cos, w_c_sin, w_c_nsin;
    logic signed [ANGLE_WIDTH-1:0] w_c_turn;

    pdbf_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_prev_x       (i_prev_x),
        .i_prev_y       (i_prev_y),
        .i_prev_heading (i_prev_heading),
        .i_cur_x        (i_cur_x),
        .i_cur_y        (i_cur_y),
        .i_cur_heading  (i_cur_heading),
        .o_valid        (w_p_valid),
        .i_stall        (w_p_stall),
        .o_dx           (w_p_dx),
        .o_dy           (w_p_dy),
        .o_z            (w_p_z),
        .o_flip         (w_p_flip),
        .o_turn         (w_p_turn)
    );

    pdbf_cordic #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .o_stall (w_p_stall),
        .i_dx    (w_p_dx),
        .i_dy    (w_p_dy),
        .i_z     (w_p_z),
        .i_flip  (w_p_flip),
        .i_turn  (w_p_turn),
        .o_valid (w_c_valid),
        .i_stall (w_c_stall),
        .o_dx    (w_c_dx),
        .o_dy    (w_c_dy),
        .o_cos   (w_c_cos),
        .o_sin   (w_c_sin),
        .o_nsin  (w_c_nsin),
        .o_turn  (w_c_turn)
    );

    pdbf_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_rotate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_c_valid),
        .o_stall        (w_c_stall),
        .i_dx           (w_c_dx),
        .i_dy           (w_c_dy),
        .i_cos          (w_c_cos),
        .i_sin          (w_c_sin),
        .i_nsin         (w_c_nsin),
        .i_turn         (w_c_turn),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_forward_move (o_forward_move),
        .o_lateral_move (o_lateral_move),
        .o_turn         (o_turn),
        .o_saturated    (o_saturated)
    );

endmodule

`default_nettype wire

### sv/pdbf_checker.sv
// port level checks of the pose delta to body frame unit and their bind
`default_nettype none

module pdbf_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic signed [COORD_WIDTH-1:0] o_forward_move,
    input wire logic signed [COORD_WIDTH-1:0] o_lateral_move,
    input wire logic signed [ANGLE_WIDTH-1:0] o_turn,
    input wire logic                          o_saturated
);

    localparam logic signed [COORD_WIDTH-1:0] MAX_V = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MIN_V = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_forward_move)
            && $stable(o_lateral_move) && $stable(o_turn) && $stable(o_saturated))
        else $error("stalled output item changed");

    // empty output stage means the whole pipeline can move
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a clipped item shows a bound on one of its moves
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_forward_move == MAX_V || o_forward_move == MIN_V
            || o_lateral_move == MAX_V || o_lateral_move == MIN_V)
        else $error("saturated item without a bound value");

    // the output is not valid at the first clock with reset released
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid one cycle after reset");

endmodule

bind pose_delta_to_body_frame_unit pdbf_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_pdbf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_forward_move (o_forward_move),
    .o_lateral_move (o_lateral_move),
    .o_turn         (o_turn),
    .o_saturated    (o_saturated)
);

`default_nettype wire
